FILE: rtl/shs_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
package shs_pkg;

    localparam int WORD_W  = 32;
    localparam int WIN_AW  = 4;
    localparam int LEN_W   = 62;
    localparam int FILL_W  = 6;

    localparam logic [7:0]        PAD_MARK  = 8'h80;
    localparam logic [FILL_W-1:0] LEN_POS   = 6'd56;
    localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
    localparam logic [5:0]        ROUND_LAST = 6'd63;
    localparam logic [2:0]        WORD_LAST  = 3'd7;

    localparam logic [WORD_W-1:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [WORD_W-1:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_final;
    } item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        length_error;
    } result_t;

    typedef struct packed {
        logic       load_work;
        logic       capture;
        logic       do_round;
        logic       add_hash;
        logic       init_hash;
        logic [5:0] round;
    } shs_ctrl_t;

    function automatic logic [WORD_W-1:0] bsig0(input logic [WORD_W-1:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] bsig1(input logic [WORD_W-1:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WORD_W-1:0] ssig0(input logic [WORD_W-1:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [WORD_W-1:0] ssig1(input logic [WORD_W-1:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

FILE: rtl/shs_sched_ram.sv
// Sixteen-word message schedule memory: one write port, two registered read ports.
module shs_sched_ram
    import shs_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [WIN_AW-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [WIN_AW-1:0] raddr0,
    input  logic [WIN_AW-1:0] raddr1,
    output logic [WORD_W-1:0] rdata0,
    output logic [WORD_W-1:0] rdata1
);

    logic [WORD_W-1:0] mem [2**WIN_AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

FILE: rtl/shs_round_unit.sv
// Compression datapath: working variables, hash words and the round function.
module shs_round_unit
    import shs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  shs_ctrl_t         ctrl,
    input  logic [WORD_W-1:0] rd0,
    input  logic [WORD_W-1:0] rd1,
    input  logic [2:0]        word_sel,
    output logic [WORD_W-1:0] w_new,
    output logic [WORD_W-1:0] hash_word
);

    logic [WORD_W-1:0] work_reg [8];
    logic [WORD_W-1:0] hash_reg [8];
    logic [WORD_W-1:0] part_reg;
    logic              early_reg;
    logic [WORD_W-1:0] t1;
    logic [WORD_W-1:0] t2;

    always_comb
    begin
        w_new = early_reg ? part_reg : part_reg + ssig1(rd0) + rd1;
        t1 = work_reg[7] + bsig1(work_reg[4])
           + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
           + ROUND_K[ctrl.round] + w_new;
        t2 = bsig0(work_reg[0])
           + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]));
        hash_word = hash_reg[word_sel];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            early_reg <= (ctrl.round[5:4] == 2'b00);
            part_reg  <= (ctrl.round[5:4] == 2'b00) ? rd0 : rd0 + ssig0(rd1);
        end
        if (ctrl.load_work)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= hash_reg[i];
            end
        end
        else if (ctrl.do_round)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= INIT_H[i];
            end
        end
        else if (ctrl.init_hash)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= INIT_H[i];
            end
        end
        else if (ctrl.add_hash)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= hash_reg[i] + work_reg[i];
            end
        end
    end

endmodule

FILE: rtl/sha256_stream_hasher_top.sv
// SHA-256 stream hasher top level: byte packing, padding, round sequencing, digest output.
//
// Usage: the item channel (item_valid, item_stall, item) carries one message byte per
// transfer, flagged by has_byte; is_final ends the message after that transfer's byte.
// The result channel (result_valid, result_stall, result) then delivers eight digest
// words, word_index 0 first, last_word set on the eighth; length_error set with zero
// words when the message passed 2^61-1 bytes.
// Throughput: one byte per cycle while a block fills; each full 64-byte block then
// holds item_stall high during compression, whose rounds each read four schedule
// words through the two read ports of the schedule memory, in ST_RD_A and ST_RD_B.
// Finalize: padding is written one byte per cycle (up to 72 bytes), paused by one or two
// compressions and before the length bytes; ST_OLOAD loads the first word, then one
// word per cycle. A stalled result is held; the next word is loaded only on a transfer.
// After the eighth transfer the hash state reinitialises and items are taken again.
// Reset: asynchronous, active low; clears the hash to its initial value, the byte
// count and the length, and leaves the block ready for a new message.
module sha256_stream_hasher_top
    import shs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_RD_A,
        ST_RD_B,
        ST_LAST,
        ST_ADD,
        ST_OLOAD,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_MARK,
        PH_ZERO,
        PH_LEN,
        PH_DONE
    } phase_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  len_acc;
    logic [23:0]       acc_reg, acc_next;
    logic [63:0]       lsr_reg, lsr_next;
    logic              err_reg, err_next;
    logic [5:0]        round_reg, round_next;
    result_t           out_reg, out_next;

    logic              byte_we;
    logic [7:0]        byte_val;
    shs_ctrl_t         ctrl;
    logic [2:0]        word_sel;
    logic              ram_we;
    logic [WIN_AW-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WIN_AW-1:0] raddr0;
    logic [WIN_AW-1:0] raddr1;
    logic [WORD_W-1:0] rdata0;
    logic [WORD_W-1:0] rdata1;
    logic [WORD_W-1:0] w_new;
    logic [WORD_W-1:0] hash_word;

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_OUT);
    assign result       = out_reg;

    shs_sched_ram u_ram (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    shs_round_unit u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .rd0       (rdata0),
        .rd1       (rdata1),
        .word_sel  (word_sel),
        .w_new     (w_new),
        .hash_word (hash_word)
    );

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        lsr_next   = lsr_reg;
        err_next   = err_reg;
        round_next = round_reg;
        out_next   = out_reg;
        byte_we    = 1'b0;
        byte_val   = '0;
        ctrl       = '0;
        word_sel   = out_reg.word_index + 3'd1;
        raddr0     = round_reg[3:0];
        raddr1     = round_reg[3:0] + 4'd1;
        len_acc    = len_reg + {{(LEN_W-1){1'b0}}, (item.has_byte & ~len_reg[LEN_W-1])};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    byte_we  = item.has_byte;
                    byte_val = item.data_byte;
                    len_next = len_acc;
                    if (item.is_final)
                    begin
                        err_next   = len_acc[LEN_W-1];
                        lsr_next   = {len_acc[60:0], 3'b000};
                        phase_next = len_acc[LEN_W-1] ? PH_DONE : PH_MARK;
                        state_next = len_acc[LEN_W-1] ? ST_OLOAD : ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                priority case (phase_reg)
                    PH_MARK:
                    begin
                        byte_we    = 1'b1;
                        byte_val   = PAD_MARK;
                        phase_next = PH_ZERO;
                    end
                    PH_ZERO:
                    begin
                        if (fill_reg == LEN_POS)
                        begin
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            byte_we = 1'b1;
                        end
                    end
                    PH_LEN:
                    begin
                        byte_we  = 1'b1;
                        byte_val = lsr_reg[63:56];
                        lsr_next = {lsr_reg[55:0], 8'h00};
                        if (fill_reg == FILL_LAST)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_OLOAD;
                    end
                endcase
            end
            ST_RD_A:
            begin
                ctrl.do_round = (round_reg != 6'd0);
                ctrl.round    = round_reg - 6'd1;
                state_next    = ST_RD_B;
            end
            ST_RD_B:
            begin
                ctrl.capture = 1'b1;
                ctrl.round   = round_reg;
                raddr0       = round_reg[3:0] + 4'd14;
                raddr1       = round_reg[3:0] + 4'd9;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    round_next = round_reg + 6'd1;
                    state_next = ST_RD_A;
                end
            end
            ST_LAST:
            begin
                ctrl.do_round = 1'b1;
                ctrl.round    = round_reg;
                state_next    = ST_ADD;
            end
            ST_ADD:
            begin
                ctrl.add_hash = 1'b1;
                priority case (phase_reg)
                    PH_NONE: state_next = ST_IDLE;
                    PH_DONE: state_next = ST_OLOAD;
                    default: state_next = ST_PAD;
                endcase
            end
            ST_OLOAD:
            begin
                word_sel                  = 3'd0;
                out_next.digest_word      = err_reg ? '0 : hash_word;
                out_next.word_index       = 3'd0;
                out_next.last_word        = 1'b0;
                out_next.length_error     = err_reg;
                state_next                = ST_OUT;
            end
            ST_OUT:
            begin
                if (!result_stall)
                begin
                    if (out_reg.last_word)
                    begin
                        ctrl.init_hash = 1'b1;
                        fill_next      = '0;
                        len_next       = '0;
                        phase_next     = PH_NONE;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        out_next.digest_word  = err_reg ? '0 : hash_word;
                        out_next.word_index   = word_sel;
                        out_next.last_word    = (word_sel == WORD_LAST);
                        out_next.length_error = err_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (byte_we)
        begin
            fill_next = fill_reg + 6'd1;
            if (fill_reg[1:0] != 2'd3)
            begin
                acc_next = {acc_reg[15:0], byte_val};
            end
            if (fill_reg == FILL_LAST)
            begin
                ctrl.load_work = 1'b1;
                round_next     = 6'd0;
                state_next     = ST_RD_A;
            end
        end

        ram_we    = (byte_we && fill_reg[1:0] == 2'd3) || ctrl.do_round;
        ram_waddr = byte_we ? fill_reg[5:2] : ctrl.round[3:0];
        ram_wdata = byte_we ? {acc_reg, byte_val} : w_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_NONE;
            fill_reg  <= '0;
            len_reg   <= '0;
            err_reg   <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            err_reg   <= err_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        lsr_reg <= lsr_next;
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_A || state_reg == ST_RD_B || state_reg == ST_LAST)
        |=> $stable(fill_reg))
        else $error("byte count moved during compression");

    a_no_byte_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_A || state_reg == ST_RD_B || state_reg == ST_LAST)
        |-> !byte_we)
        else $error("byte write collides with schedule update");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !result.last_word)
        |=> (result.word_index == $past(result.word_index) + 3'd1))
        else $error("digest word index did not advance by one");

    a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && result.last_word)
        |=> (fill_reg == '0 && len_reg == '0 && !result_valid))
        else $error("state not reinitialised after final digest word");
`endif

endmodule
